// ===== sv/gbte_pkg.sv =====
`timescale 1ns / 1ps
package gbte_pkg;
   localparam int DEPTH = 4096;
   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

   localparam logic [3:0] K_INSERT = 4'd0;
   localparam logic [3:0] K_BACK = 4'd1;
   localparam logic [3:0] K_LEFT = 4'd2;
   localparam logic [3:0] K_RIGHT = 4'd3;
   localparam logic [3:0] K_START = 4'd4;
   localparam logic [3:0] K_UP = 4'd5;
   localparam logic [3:0] K_DOWN = 4'd6;
   localparam logic [3:0] K_UP_ABS = 4'd7;
   localparam logic [3:0] K_DOWN_ABS = 4'd8;
   localparam logic [3:0] K_WORD_LEFT = 4'd9;
   localparam logic [3:0] K_WORD_RIGHT = 4'd10;
   localparam logic [3:0] K_TO_COLUMN = 4'd11;

   localparam logic [7:0] CH_NL = 8'h0a;
   localparam logic [7:0] CH_US = 8'h5f;
   localparam logic [7:0] CH_SQ = 8'h27;
   localparam logic [7:0] CH_DQ = 8'h22;

   typedef struct packed {
      logic [3:0]  kind;
      logic [7:0]  ch;
      logic [11:0] column;
   } req_type;

   typedef struct packed {
      logic [11:0] cursor;
      logic [11:0] length;
      logic [7:0]  char_before;
      logic [7:0]  char_after;
      logic        at_start;
      logic        at_end;
      logic        full_drop;
   } rsp_type;

   function automatic logic [1:0] char_class(input logic [7:0] c);
      if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) return 2'd0;
      if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
          (c >= 8'h61 && c <= 8'h7a) || c == CH_US || c == CH_SQ || c == CH_DQ)
         return 2'd1;
      return 2'd2;
   endfunction
endpackage

// ===== sv/gap_buffer_text_engine_top.sv =====
`timescale 1ns / 1ps
// channel   ports                        direction  handshake
// request   req_data (kind, ch, column)  in         start & !busy
// response  rsp_data (status)            out        rsp_valid, one cycle
//
// one memory of DEPTH bytes, one read and one write port; a move step reads the
// neighbor, checks it and writes it across the gap (S_RDB/S_RDA, S_EVAL, S_WR)
// simple edits pass S_DISP, S_STB, S_STA and S_DONE after the accept, the result
// out of S_DONE; motions add a move step per character walked, a read and check
// per stop check and an S_DISP pass per phase; the down column count stays in S_EVAL
// reset (synchronous) empties the text; the store itself is not cleared
// results cannot be stalled; busy holds off the next command
module gap_buffer_text_engine_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  gbte_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output gbte_pkg::rsp_type    rsp_data
);
   import gbte_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_DISP  = 9'b000000010,
      S_RDB   = 9'b000000100, // read char before
      S_RDA   = 9'b000001000, // read char after
      S_EVAL  = 9'b000010000, // decide with fetched char
      S_WR    = 9'b000100000, // write moved char
      S_STB   = 9'b001000000,
      S_STA   = 9'b010000000,
      S_DONE  = 9'b100000000
   } state_type;

   // phases within a command
   typedef enum logic [2:0] {
      P0, P1, P2, P3, P4
   } phase_type;

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;
   logic [AW-1:0] raddr;
   logic mwe;
   logic [AW-1:0] waddr;
   logic [7:0] wdata;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   req_type cmd_ff, cmd_in;
   logic [AW-1:0] gl_ff, gl_in, gr_ff, gr_in;
   logic [11:0] col_ff, col_in;
   logic [1:0] cls_ff, cls_in;
   logic first_ff, first_in;
   logic dir_ff, dir_in; // 1 = move right
   logic drop_ff, drop_in;
   logic [7:0] cb_ff, cb_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   always_ff @(posedge clock) begin
      if (mwe) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   wire hb = gl_ff != '0;
   wire ha = gr_ff != LAST;
   wire [7:0] rd = rdata_ff;

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; cmd_in = cmd_ff;
      gl_in = gl_ff; gr_in = gr_ff; col_in = col_ff; cls_in = cls_ff;
      first_in = first_ff; dir_in = dir_ff; drop_in = drop_ff; cb_in = cb_ff;
      rsp_valid_in = 1'b0; rsp_in = rsp_ff;
      raddr = gl_ff - AW'(1); mwe = 1'b0; waddr = gr_ff; wdata = rd;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in = req_data; state_in = S_DISP; phase_in = P0;
               drop_in = 1'b0; col_in = '0; first_in = 1'b1;
            end
         end
         S_DISP: begin
            // each phase: choose a walk or finish
            state_in = S_STB;
            case (cmd_ff.kind)
               K_INSERT: if (gl_ff == gr_ff) drop_in = 1'b1;
                  else begin
                     mwe = 1'b1; waddr = gl_ff; wdata = cmd_ff.ch; gl_in = gl_ff + AW'(1);
                  end
               K_BACK: if (hb) gl_in = gl_ff - AW'(1);
               K_LEFT: if (phase_ff == P0) begin
                     phase_in = P1; dir_in = 1'b0; first_in = 1'b0;
                     state_in = hb ? S_RDB : S_STB;
                     cls_in = 2'd3; // walk exactly one step
                  end
               K_RIGHT: if (phase_ff == P0) begin
                     phase_in = P1; dir_in = 1'b1; cls_in = 2'd3;
                     state_in = ha ? S_RDA : S_STB;
                  end
               K_START: if (hb) begin dir_in = 1'b0; cls_in = 2'd2; state_in = S_RDB; end
               K_UP, K_UP_ABS, K_DOWN, K_DOWN_ABS, K_TO_COLUMN, K_WORD_LEFT,
               K_WORD_RIGHT: state_in = S_EVAL;
               default: ;
            endcase
            if (state_in == S_EVAL) begin
               // line/word plan by phase; cls_ff encodes walk mode
               state_in = S_STB;
               case (cmd_ff.kind)
                  K_UP, K_UP_ABS: case (phase_ff)
                     P0: begin phase_in = P1; dir_in = 1'b0; cls_in = 2'd0;
                        col_in = '0; if (hb) state_in = S_RDB; end
                     P1: begin phase_in = P2; dir_in = 1'b0; cls_in = 2'd3;
                        state_in = hb ? S_RDB : S_DISP; end
                     P2: if (cmd_ff.kind == K_UP) begin
                        phase_in = P3; dir_in = 1'b0; cls_in = 2'd0;
                        state_in = hb ? S_RDB : S_DISP; end
                     P3: begin phase_in = P4; dir_in = 1'b1; cls_in = 2'd1;
                        if (ha && col_ff != '0) state_in = S_RDA; end
                     default: ;
                  endcase
                  K_DOWN: case (phase_ff)
                     P0: begin phase_in = P1; dir_in = 1'b0; cls_in = 2'd0;
                        col_in = '0; state_in = hb ? S_RDB : S_DISP; end
                     P1: begin phase_in = P2; dir_in = 1'b1; cls_in = 2'd0;
                        if (ha) state_in = S_RDA; end
                     P2: begin phase_in = P3; dir_in = 1'b1; cls_in = 2'd3;
                        state_in = ha ? S_RDA : S_DISP; end
                     P3: begin phase_in = P4; dir_in = 1'b0; cls_in = 2'd0;
                        if (hb) state_in = S_RDB; end
                     P4: begin phase_in = P2; cmd_in.kind = K_TO_COLUMN;
                        dir_in = 1'b1; cls_in = 2'd1;
                        if (ha && col_ff != '0) state_in = S_RDA; end
                     default: ;
                  endcase
                  K_DOWN_ABS: case (phase_ff)
                     P0: begin phase_in = P1; dir_in = 1'b1; cls_in = 2'd0;
                        if (ha) state_in = S_RDA; end
                     P1: begin phase_in = P2; dir_in = 1'b1; cls_in = 2'd3;
                        if (ha) state_in = S_RDA; end
                     P2: begin phase_in = P3; dir_in = 1'b1; cls_in = 2'd0;
                        if (ha) state_in = S_RDA; end
                     default: ;
                  endcase
                  K_TO_COLUMN: case (phase_ff)
                     P0: begin phase_in = P1; dir_in = 1'b0; cls_in = 2'd0;
                        col_in = cmd_ff.column; state_in = hb ? S_RDB : S_DISP; end
                     P1: begin phase_in = P2; dir_in = 1'b1; cls_in = 2'd1;
                        if (ha && col_ff != '0) state_in = S_RDA; end
                     default: ;
                  endcase
                  default: if (phase_ff == P0) begin // word motions
                     phase_in = P1; first_in = 1'b1; cls_in = 2'd2;
                     dir_in = cmd_ff.kind == K_WORD_RIGHT;
                     if (dir_in ? ha : hb) state_in = dir_in ? S_RDA : S_RDB;
                  end
               endcase
            end
         end
         S_RDB: begin raddr = gl_ff - AW'(1); state_in = S_EVAL; end
         S_RDA: begin raddr = gr_ff + AW'(1); state_in = S_EVAL; end
         S_EVAL: begin
            // cls_ff: 0 walk to newline (col counted on the first walk of up and down), 1 walk col chars
            // to newline, 2 start/word, 3 single step
            logic go;
            go = 1'b1;
            // keep the neighbor on the read port for the write that follows
            raddr = dir_ff ? gr_ff + AW'(1) : gl_ff - AW'(1);
            case (cls_ff)
               2'd0: go = rd != CH_NL;
               2'd1: go = rd != CH_NL;
               2'd2: if (cmd_ff.kind == K_START) go = 1'b1;
                  else if (first_ff) begin cb_in = {6'd0, char_class(rd)}; first_in = 1'b0; end
                  else go = char_class(rd) == cb_ff[1:0];
               default: go = 1'b1;
            endcase
            if (go && cls_ff == 2'd0 && cmd_ff.kind == K_DOWN && phase_ff == P1) begin
               // counting only: advance a read pointer without moving
               col_in = col_ff + 12'd1;
               if (AW'(col_ff) + AW'(1) < gl_ff && col_ff != 12'hfff) begin
                  raddr = gl_ff - AW'(2) - AW'(col_ff);
                  state_in = S_EVAL;
               end else state_in = S_DISP;
               if (rd == CH_NL) state_in = S_DISP;
            end else if (cmd_ff.kind == K_DOWN && phase_ff == P1) state_in = S_DISP;
            else if (go) state_in = S_WR;
            else state_in = S_DISP;
         end
         S_WR: begin
            mwe = 1'b1;
            if (dir_ff) begin
               waddr = gl_ff; gl_in = gl_ff + AW'(1); gr_in = gr_ff + AW'(1);
            end else begin
               waddr = gr_ff; gl_in = gl_ff - AW'(1); gr_in = gr_ff - AW'(1);
            end
            // column count only on the first walk of up
            if (cls_ff == 2'd0 && !dir_ff && cmd_ff.kind == K_UP && phase_ff == P1)
               col_in = col_ff + 12'd1;
            if (cls_ff == 2'd1) col_in = col_ff - 12'd1;
            state_in = S_DISP;
            if (cls_ff != 2'd3) begin
               if (dir_ff ? (gr_in != LAST) : (gl_in != '0)) begin
                  if (!(cls_ff == 2'd1 && col_in == '0)) state_in = dir_ff ? S_RDA : S_RDB;
               end
            end
         end
         S_STB: begin raddr = gl_ff - AW'(1); state_in = S_STA; end
         S_STA: begin raddr = gr_ff + AW'(1); cb_in = rd; state_in = S_DONE; end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.cursor = 12'(gl_ff);
            rsp_in.length = 12'(gl_ff + (LAST - gr_ff));
            rsp_in.char_before = hb ? cb_ff : 8'd0;
            rsp_in.char_after = ha ? rd : 8'd0;
            rsp_in.at_start = !hb;
            rsp_in.at_end = !ha;
            rsp_in.full_drop = drop_ff;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; phase_ff <= P0; gl_ff <= '0; gr_ff <= LAST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; gl_ff <= gl_in; gr_ff <= gr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in; col_ff <= col_in; cls_ff <= cls_in; first_ff <= first_in;
      dir_ff <= dir_in; drop_ff <= drop_in; cb_ff <= cb_in; rsp_ff <= rsp_in;
   end

   assign busy = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   a_gap: assert property (@(posedge clock) disable iff (reset) gl_ff <= gr_ff)
      else $error("gap closed");
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && !start |=> $stable(gl_ff) && $stable(gr_ff))
      else $error("gap moved while idle");
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == S_IDLE) else $error("stray response");
endmodule
